### src/dpsp_pkg.sv
`default_nettype none
package dpsp_pkg;
    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS = 32;
    localparam int POS_BITS = 10;
    localparam int SUM_BITS = 11;
    localparam int DIV_BITS = 22;
    localparam int CNT_BITS = 5;

    localparam logic [2:0] REG_REST_A = 3'd0;
    localparam logic [2:0] REG_FULL_A = 3'd1;
    localparam logic [2:0] REG_REST_B = 3'd2;
    localparam logic [2:0] REG_FULL_B = 3'd3;
    localparam logic [2:0] REG_DEADBAND = 3'd4;
    localparam logic [2:0] REG_GRACE = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_DECIDE,
        ST_DIV_T,
        ST_PCT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    function automatic logic [SAMPLE_BITS-1:0] med3(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end else if (c >= hi) begin
            return hi;
        end
        return c;
    endfunction
endpackage
`default_nettype wire

### src/dual_pedal_sensor_plausibility_core.sv
// Each word runs the bit-serial divider for the channel maps and the throttle
// rescale only where one is needed, and always for the two percent scalings.
// The divider is shared by both channel maps, the throttle rescale and the
// percent scaling. A new word is taken only once the result has been taken
// and the core is back in idle, so one word is handled at a time.
// Reset (synchronous, active low) restores calibration defaults and clears
// the filter history, the fault timer and all handshake state.
`default_nettype none
module dual_pedal_sensor_plausibility_core (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire logic [11:0] s_sample_a,
    input  wire logic [11:0] s_sample_b,
    input  wire logic [31:0] s_now_ms,
    output logic m_valid,
    input  wire logic m_ready,
    output logic [9:0] m_throttle,
    output logic [6:0] m_pedal_a_pct,
    output logic [6:0] m_pedal_b_pct,
    output logic m_implausible,
    output logic m_signal_cut,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    import dpsp_pkg::*;

    localparam int SB = SAMPLE_BITS;

    state_t st_reg, st_next;
    logic [SB-1:0] rest_a_reg, full_a_reg, rest_b_reg, full_b_reg;
    logic [6:0] db_reg;
    logic [15:0] grace_reg;
    logic [SB-1:0] ha_reg [3];
    logic [SB-1:0] hb_reg [3];
    logic [1:0] slot_reg;
    logic fact_reg;
    logic [TIME_BITS-1:0] fstart_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [SB-1:0] mb_reg;
    logic fa_reg, fb_reg;
    logic [POS_BITS-1:0] pa_reg, pb_reg;
    logic [SUM_BITS-1:0] s_reg;
    logic [1:0] pct_reg;
    logic imp_reg, cut_reg;
    logic [9:0] thr_reg;
    logic [6:0] pcta_reg, pctb_reg;
    logic mv_reg;

    div_req_t dreq;
    logic dbusy;
    logic [DIV_BITS-1:0] dq;

    dpsp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(dreq), .busy(dbusy), .quot(dq)
    );

    // Window bounds compared in hundredths, so only constant multiplications remain.
    function automatic logic fault_of(
        input logic [SB-1:0] x, input logic [SB-1:0] r, input logic [SB-1:0] f
    );
        logic [SB-1:0] lo;
        logic [SB-1:0] hi;
        logic [SB+7:0] lo85;
        logic [SB+7:0] hi115;
        logic [SB+7:0] x100;
        logic [SB+7:0] xp100;
        lo = (r < f) ? r : f;
        hi = (r < f) ? f : r;
        lo85 = (SB + 8)'(lo) * (SB + 8)'(85);
        hi115 = (SB + 8)'(hi) * (SB + 8)'(115);
        x100 = (SB + 8)'(x) * (SB + 8)'(100);
        xp100 = x100 + (SB + 8)'(100);
        return (xp100 <= lo85) || (x100 > hi115);
    endfunction

    function automatic logic [POS_BITS-1:0] clamp_q(input logic [DIV_BITS-1:0] q);
        return (q > 1000) ? POS_BITS'(1000) : q[POS_BITS-1:0];
    endfunction

    logic [9:0] dval;
    logic [SUM_BITS:0] twod;
    logic [SB-1:0] med_a, med_b;
    logic [TIME_BITS-1:0] elapsed;
    logic in_grace;
    logic [POS_BITS-1:0] diff, pmin;
    logic plaus_ok;
    logic [SUM_BITS-1:0] s_norm;
    logic [SUM_BITS-1:0] s_fin;
    logic cut_w;

    always_comb begin
        dval = 10'((db_reg > 7'd95 ? 7'd95 : db_reg) * 10);
        twod = {1'b0, dval, 1'b0};
        med_a = med3(ha_reg[0], ha_reg[1], ha_reg[2]);
        med_b = med3(hb_reg[0], hb_reg[1], hb_reg[2]);
        diff = (pa_reg > pb_reg) ? pa_reg - pb_reg : pb_reg - pa_reg;
        pmin = (pa_reg < pb_reg) ? pa_reg : pb_reg;
        plaus_ok = !fa_reg && !fb_reg && (diff < 10'd100);
        elapsed = now_reg - (fact_reg ? fstart_reg : now_reg);
        in_grace = elapsed < TIME_BITS'(grace_reg);
        s_norm = SUM_BITS'(pa_reg) + SUM_BITS'(pb_reg);
        if (s_norm <= 11'd20) s_norm = '0;
        if (s_norm > 11'd1980) s_norm = 11'd2000;
        cut_w = 1'b0;
        if (plaus_ok) begin
            s_fin = s_norm;
        end else if (!in_grace) begin
            s_fin = '0;
            cut_w = 1'b1;
        end else if (fa_reg && !fb_reg) begin
            s_fin = {pb_reg, 1'b0};
        end else if (fb_reg && !fa_reg) begin
            s_fin = {pa_reg, 1'b0};
        end else begin
            s_fin = {pmin, 1'b0};
        end
    end

    logic start_w;
    logic dfirst_reg;

    always_comb begin
        st_next = st_reg;
        dreq = '0;
        start_w = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (s_valid) st_next = ST_DIV_A;
            end
            ST_DIV_A: begin
                if (dfirst_reg) begin
                    dreq.start = ((med_a > rest_a_reg) && (full_a_reg > rest_a_reg))
                        || ((med_a < rest_a_reg) && (full_a_reg < rest_a_reg));
                    dreq.num = DIV_BITS'(((med_a > rest_a_reg) ? med_a - rest_a_reg
                        : rest_a_reg - med_a) * 1000);
                    dreq.den = DIV_BITS'((full_a_reg > rest_a_reg) ? full_a_reg - rest_a_reg
                        : rest_a_reg - full_a_reg);
                    if (!dreq.start) start_w = 1'b1;
                end else if (!dbusy) begin
                    start_w = 1'b1;
                end
                if (start_w) st_next = ST_DIV_B;
            end
            ST_DIV_B: begin
                if (dfirst_reg) begin
                    dreq.start = ((mb_reg > rest_b_reg) && (full_b_reg > rest_b_reg))
                        || ((mb_reg < rest_b_reg) && (full_b_reg < rest_b_reg));
                    dreq.num = DIV_BITS'(((mb_reg > rest_b_reg) ? mb_reg - rest_b_reg
                        : rest_b_reg - mb_reg) * 1000);
                    dreq.den = DIV_BITS'((full_b_reg > rest_b_reg) ? full_b_reg - rest_b_reg
                        : rest_b_reg - full_b_reg);
                    if (!dreq.start) start_w = 1'b1;
                end else if (!dbusy) begin
                    start_w = 1'b1;
                end
                if (start_w) st_next = ST_DECIDE;
            end
            ST_DECIDE: st_next = ST_DIV_T;
            ST_DIV_T: begin
                if (dfirst_reg) begin
                    dreq.start = ({1'b0, s_fin} > twod);
                    dreq.num = DIV_BITS'(({1'b0, s_fin} - twod) * 1000);
                    dreq.den = DIV_BITS'({(10'd1000 - dval), 1'b0});
                    if (!dreq.start) start_w = 1'b1;
                end else if (!dbusy) begin
                    start_w = 1'b1;
                end
                if (start_w) st_next = ST_PCT;
            end
            ST_PCT: begin
                if (dfirst_reg) begin
                    dreq.start = 1'b1;
                    dreq.num = DIV_BITS'(pct_reg[0] ? pb_reg : pa_reg);
                    dreq.den = DIV_BITS'(10);
                end else if (!dbusy) begin
                    start_w = 1'b1;
                end
                if (start_w && pct_reg[0]) st_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_a_reg <= '0;
            full_a_reg <= '1;
            rest_b_reg <= '0;
            full_b_reg <= '1;
            db_reg <= '0;
            grace_reg <= 16'd100;
            for (int i = 0; i < 3; i++) begin
                ha_reg[i] <= '0;
                hb_reg[i] <= '0;
            end
            slot_reg <= '0;
            fact_reg <= 1'b0;
            fstart_reg <= '0;
            mv_reg <= 1'b0;
            dfirst_reg <= 1'b0;
            pct_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_REST_A: rest_a_reg <= cfg_data[SB-1:0];
                    REG_FULL_A: full_a_reg <= cfg_data[SB-1:0];
                    REG_REST_B: rest_b_reg <= cfg_data[SB-1:0];
                    REG_FULL_B: full_b_reg <= cfg_data[SB-1:0];
                    REG_DEADBAND: db_reg <= cfg_data[6:0];
                    REG_GRACE: grace_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            dfirst_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ha_reg[slot_reg] <= s_sample_a;
                        hb_reg[slot_reg] <= s_sample_b;
                        slot_reg <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                        now_reg <= s_now_ms;
                        dfirst_reg <= 1'b1;
                    end
                end
                ST_DIV_A: begin
                    if (dfirst_reg) begin
                        mb_reg <= med_b;
                        fa_reg <= fault_of(med_a, rest_a_reg, full_a_reg);
                        fb_reg <= fault_of(med_b, rest_b_reg, full_b_reg);
                    end
                    if (start_w) begin
                        pa_reg <= dfirst_reg ? '0 : clamp_q(dq);
                        dfirst_reg <= 1'b1;
                    end
                end
                ST_DIV_B: begin
                    if (start_w) begin
                        pb_reg <= dfirst_reg ? '0 : clamp_q(dq);
                    end
                end
                ST_DECIDE: begin
                    if (pa_reg == '0 || pb_reg == '0) begin
                        pa_reg <= '0;
                        pb_reg <= '0;
                    end
                    dfirst_reg <= 1'b1;
                end
                ST_DIV_T: begin
                    if (dfirst_reg) begin
                        s_reg <= s_fin;
                        imp_reg <= !plaus_ok;
                        cut_reg <= cut_w;
                        if (plaus_ok) begin
                            fact_reg <= 1'b0;
                        end else if (!fact_reg) begin
                            fact_reg <= 1'b1;
                            fstart_reg <= now_reg;
                        end
                    end
                    if (start_w) begin
                        thr_reg <= dfirst_reg ? '0 : clamp_q(dq);
                        pct_reg <= '0;
                        dfirst_reg <= 1'b1;
                    end
                end
                ST_PCT: begin
                    if (start_w) begin
                        if (pct_reg[0]) begin
                            pctb_reg <= dq[6:0];
                            mv_reg <= 1'b1;
                        end else begin
                            pcta_reg <= dq[6:0];
                            pct_reg <= 2'd1;
                            dfirst_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The divider start in the first DIV_T cycle comes before s_reg is
    // loaded, so the throttle numerator is taken from s_fin there instead.
    assign m_valid = mv_reg;
    assign m_throttle = thr_reg;
    assign m_pedal_a_pct = pcta_reg;
    assign m_pedal_b_pct = pctb_reg;
    assign m_implausible = imp_reg;
    assign m_signal_cut = cut_reg;

`ifndef SYNTHESIS
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_throttle <= 10'd1000))
        else $error("throttle out of range");
    a_cut_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_signal_cut) |-> (m_throttle == '0 && m_implausible))
        else $error("cut without zero throttle");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
`endif
endmodule
`default_nettype wire

### src/dpsp_div.sv
`default_nettype none
module dpsp_div (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire dpsp_pkg::div_req_t req,
    output logic busy,
    output logic [dpsp_pkg::DIV_BITS-1:0] quot
);
    import dpsp_pkg::*;

    // Restoring division, one quotient bit per cycle.
    logic [DIV_BITS-1:0] q_reg, q_next;
    logic [DIV_BITS-1:0] r_reg, r_next;
    logic [DIV_BITS-1:0] d_reg, d_next;
    logic [CNT_BITS-1:0] n_reg, n_next;
    logic [DIV_BITS:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        trial = {r_reg, q_reg[DIV_BITS-1]} - {1'b0, d_reg};
        if (req.start) begin
            q_next = req.num;
            r_next = '0;
            d_next = req.den;
            n_next = CNT_BITS'(DIV_BITS);
        end else if (n_reg != '0) begin
            n_next = n_reg - 1'b1;
            if (!trial[DIV_BITS]) begin
                r_next = trial[DIV_BITS-1:0];
                q_next = {q_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                r_next = {r_reg[DIV_BITS-2:0], q_reg[DIV_BITS-1]};
                q_next = {q_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else begin
            n_reg <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (n_reg != '0);
    assign quot = q_reg;
endmodule
`default_nettype wire

### test/dual_pedal_sensor_plausibility_core_tb.sv
`default_nettype none
module dual_pedal_sensor_plausibility_core_tb;
    import dpsp_pkg::*;

    typedef struct packed {
        logic [9:0] throttle;
        logic [6:0] pct_a;
        logic [6:0] pct_b;
        logic       implausible;
        logic       cut;
    } pedal_word_t;

    class pedal_scoreboard;
        int unsigned rest_a, full_a, rest_b, full_b, deadband, grace;
        int unsigned hist_a[3], hist_b[3];
        int unsigned slot;
        bit fault_on;
        logic [31:0] fault_t0;
        pedal_word_t pending[$];
        int mismatches;

        function new();
            rest_a = 0; full_a = 4095; rest_b = 0; full_b = 4095;
            deadband = 0; grace = 100;
            hist_a = '{0, 0, 0}; hist_b = '{0, 0, 0};
            slot = 0; fault_on = 0; fault_t0 = '0; mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_REST_A: rest_a = val[11:0];
                REG_FULL_A: full_a = val[11:0];
                REG_REST_B: rest_b = val[11:0];
                REG_FULL_B: full_b = val[11:0];
                REG_DEADBAND: deadband = val[6:0];
                REG_GRACE: grace = val;
                default: ;
            endcase
        endfunction

        function int unsigned median(int unsigned a, int unsigned b, int unsigned c);
            int unsigned t;
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) b = a;
            return b;
        endfunction

        function bit out_of_window(int unsigned x, int unsigned r, int unsigned f);
            int unsigned lo, hi;
            lo = r < f ? r : f;
            hi = r > f ? r : f;
            return x < lo * 85 / 100 || x > hi * 115 / 100;
        endfunction

        function longint position(int unsigned x, int unsigned r, int unsigned f);
            longint q;
            if (r == f) return 0;
            q = ((longint'(x) - longint'(r)) * 1000) / (longint'(f) - longint'(r));
            if (q < 0) q = 0;
            if (q > 1000) q = 1000;
            return q;
        endfunction

        function void note_sample(logic [11:0] sa, logic [11:0] sb, logic [31:0] now);
            int unsigned ma, mb, d;
            bit fa, fb, bad, cut;
            longint pa, pb, diff, s, thr;
            pedal_word_t w;
            logic [31:0] elapsed;
            hist_a[slot] = sa; hist_b[slot] = sb;
            slot = slot == 2 ? 0 : slot + 1;
            ma = median(hist_a[0], hist_a[1], hist_a[2]);
            mb = median(hist_b[0], hist_b[1], hist_b[2]);
            fa = out_of_window(ma, rest_a, full_a);
            fb = out_of_window(mb, rest_b, full_b);
            pa = position(ma, rest_a, full_a);
            pb = position(mb, rest_b, full_b);
            if (pa <= 0 || pb <= 0) begin pa = 0; pb = 0; end
            diff = pa > pb ? pa - pb : pb - pa;
            bad = fa || fb || diff >= 100;
            cut = 0;
            if (bad) begin
                if (!fault_on) begin fault_t0 = now; fault_on = 1; end
                elapsed = now - fault_t0;
                if (elapsed < grace) begin
                    if (fa && !fb) s = 2 * pb;
                    else if (fb && !fa) s = 2 * pa;
                    else s = 2 * (pa < pb ? pa : pb);
                end else begin
                    s = 0; cut = 1;
                end
            end else begin
                fault_on = 0;
                s = pa + pb;
                if (s <= 20) s = 0;
                if (s > 1980) s = 2000;
            end
            d = (deadband > 95 ? 95 : deadband) * 10;
            if (s <= 2 * d) thr = 0;
            else begin
                thr = ((s - 2 * d) * 1000) / (2 * (1000 - d));
                if (thr > 1000) thr = 1000;
            end
            w.throttle = thr[9:0];
            w.pct_a = 7'(pa / 10);
            w.pct_b = 7'(pb / 10);
            w.implausible = bad;
            w.cut = cut;
            pending.push_back(w);
        endfunction

        function void check_word(pedal_word_t got);
            pedal_word_t exp_w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word %p", got);
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w) begin
                mismatches++;
                if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_w, got);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, m_ready = 0, cfg_valid = 0;
    logic [11:0] s_sample_a = '0, s_sample_b = '0;
    logic [31:0] s_now_ms = '0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_ready, m_valid, m_implausible, m_signal_cut, cfg_ready;
    logic [9:0] m_throttle;
    logic [6:0] m_pedal_a_pct, m_pedal_b_pct;

    pedal_scoreboard sb = new();
    logic [31:0] clock_ms = 0;
    int quiet_tx = 0, quiet_rx = 0;
    longint cycles = 0;
    bit done = 0;

    dual_pedal_sensor_plausibility_core uut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("[dual_pedal_sensor_plausibility_core] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word({m_throttle, m_pedal_a_pct, m_pedal_b_pct, m_implausible,
                           m_signal_cut});
        if (quiet_rx > 0) m_ready <= 1;
        else m_ready <= ($urandom_range(99) >= 12);
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic send(logic [11:0] a, logic [11:0] b, logic [31:0] now);
        while (quiet_tx == 0 && $urandom_range(99) < 12) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_sample_a <= a; s_sample_b <= b; s_now_ms <= now;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(a, b, now);
    endtask

    task automatic calibrate(int unsigned ra, int unsigned fa, int unsigned rb,
                             int unsigned fb, int unsigned db, int unsigned gr);
        drain();
        write_reg(REG_REST_A, 16'(ra)); write_reg(REG_FULL_A, 16'(fa));
        write_reg(REG_REST_B, 16'(rb)); write_reg(REG_FULL_B, 16'(fb));
        write_reg(REG_DEADBAND, 16'(db)); write_reg(REG_GRACE, 16'(gr));
        write_reg(3'd7, 16'hFFFF);
        cfg_valid <= 0;
    endtask

    task automatic pedal_run(int n);
        int unsigned frac, ra, rb, va, vb, kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            frac = $urandom_range(1000);
            ra = 32'(sb.rest_a + (longint'(sb.full_a) - sb.rest_a) * frac / 1000);
            rb = 32'(sb.rest_b + (longint'(sb.full_b) - sb.rest_b) * frac / 1000);
            if (kind < 70) begin
                va = ra + $urandom_range(40) - 20;
                vb = rb + $urandom_range(40) - 20;
            end else if (kind < 85) begin
                va = ra; vb = $urandom_range(4095);
            end else begin
                va = $urandom_range(4095); vb = $urandom_range(4095);
            end
            clock_ms += $urandom_range(99) < 90 ? $urandom_range(30) : $urandom;
            send(va[11:0], vb[11:0], clock_ms);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send(12'd0, 12'd0, 32'd0);
        send(12'hFFF, 12'hFFF, 32'd1);
        send(12'hFFF, 12'hFFF, 32'd2);
        send(12'hFFF, 12'd0, 32'd3);
        send(12'hFFF, 12'd0, 32'd50);
        send(12'hFFF, 12'd0, 32'd200);
        send(12'd2048, 12'd2048, 32'd201);
        send(12'd2048, 12'd2048, 32'd202);
        calibrate(500, 500, 300, 3800, 100, 0);
        send(12'd500, 12'd2000, 32'hFFFF_FFFE);
        send(12'd500, 12'd2000, 32'hFFFF_FFFF);
        calibrate(3800, 400, 350, 3700, 96, 65535);
        send(12'd2000, 12'd2000, 32'hFFFF_FFF0);
        send(12'd100, 12'd3900, 32'hFFFF_FFF8);
        send(12'd100, 12'd3900, 32'h0000_0005);
        send(12'd100, 12'd3900, 32'h0000_0006);
        calibrate(4095, 0, 0, 4095, 0, 20);
        send(12'd0, 12'd4095, 32'd10);
        send(12'd0, 12'd4095, 32'd11);
        send(12'hAAA, 12'h555, 32'hAAAA_AAAA);
        send(12'h555, 12'hAAA, 32'h5555_5555);
        for (int p = 0; p < 8; p++) begin
            if (p == 3) quiet_tx = 1;
            if (p == 4) begin quiet_tx = 0; quiet_rx = 0; end
            if (p == 3) quiet_rx = 1;
            case (p)
                0: calibrate(0, 4095, 0, 4095, 0, 100);
                1: calibrate(400, 3600, 3600, 400, 10, 50);
                2: calibrate(200, 3900, 300, 2000, 95, 5);
                3: calibrate(600, 3000, 500, 3500, 20, 1000);
                4: calibrate(1000, 1000, 0, 4095, 0, 65535);
                5: calibrate(3900, 100, 4000, 50, 100, 0);
                6: calibrate($urandom_range(2000), 2000 + $urandom_range(2095),
                             $urandom_range(2000), 2000 + $urandom_range(2095),
                             $urandom_range(100), $urandom_range(65535));
                default: calibrate(0, 4095, 0, 4095, 0, 100);
            endcase
            pedal_run(200);
        end
        s_valid <= 0;
        quiet_rx = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[dual_pedal_sensor_plausibility_core] OK");
        else
            $display("[dual_pedal_sensor_plausibility_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
